// ===== rtl/jsu_pkg.sv =====
// shared types, codes and a helper function for the json string unescape unit
package jsu_pkg;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STRING = 2'd1;
  localparam logic [1:0] MODE_ESCAPE = 2'd2;
  localparam logic [1:0] MODE_HEX    = 2'd3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_ESCAPE = 2'd0;
  localparam logic [1:0] ERR_HEX    = 2'd1;
  localparam logic [1:0] ERR_NOTSTR = 2'd2;
  localparam logic [1:0] ERR_END    = 2'd3;

  // results caused by one request; cnt of zero means none
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] kind;
    logic [1:0] err;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } jsu_grp_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsu_hex_t;

  function automatic jsu_hex_t hex_digit(input logic [7:0] c);
    jsu_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/jsu_decode.sv =====
// parser state and combinational decode of one text byte into a result group
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output jsu_grp_t   grp
);

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [11:0] cp_r, cp_nxt;
  jsu_hex_t    hx;
  logic [15:0] cp_full;

  assign hx      = hex_digit(in_byte);
  assign cp_full = {cp_r, hx.val};

  always_comb begin
    mode_nxt = mode_r;
    hcnt_nxt = hcnt_r;
    cp_nxt   = cp_r;
    grp      = '0;
    if (in_end) begin
      if (mode_r != MODE_IDLE) begin
        mode_nxt = MODE_IDLE;
        hcnt_nxt = 2'd0;
        cp_nxt   = 12'd0;
        grp.cnt  = 2'd1;
        grp.kind = KIND_ERROR;
        grp.err  = ERR_END;
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          unique case (in_byte) inside
            8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h20: ;
            8'h22: mode_nxt = MODE_STRING;
            default: begin
              grp.cnt  = 2'd1;
              grp.kind = KIND_ERROR;
              grp.err  = ERR_NOTSTR;
            end
          endcase
        end
        MODE_STRING: begin
          if (in_byte == 8'h22) begin
            mode_nxt = MODE_IDLE;
            hcnt_nxt = 2'd0;
            cp_nxt   = 12'd0;
            grp.cnt  = 2'd1;
            grp.kind = KIND_DONE;
          end else if (in_byte == 8'h5c) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            grp.cnt  = 2'd1;
            grp.kind = KIND_DATA;
            grp.b0   = in_byte;
          end
        end
        MODE_ESCAPE: begin
          mode_nxt = MODE_STRING;
          grp.cnt  = 2'd1;
          grp.kind = KIND_DATA;
          unique case (in_byte) inside
            8'h22, 8'h2f, 8'h5c: grp.b0 = in_byte;
            8'h62: grp.b0 = 8'h08;
            8'h66: grp.b0 = 8'h0c;
            8'h6e: grp.b0 = 8'h0a;
            8'h72: grp.b0 = 8'h0d;
            8'h74: grp.b0 = 8'h09;
            8'h75: begin
              mode_nxt = MODE_HEX;
              hcnt_nxt = 2'd0;
              cp_nxt   = 12'd0;
              grp.cnt  = 2'd0;
            end
            default: begin
              mode_nxt = MODE_IDLE;
              hcnt_nxt = 2'd0;
              cp_nxt   = 12'd0;
              grp.kind = KIND_ERROR;
              grp.err  = ERR_ESCAPE;
            end
          endcase
        end
        MODE_HEX: begin
          if (!hx.ok) begin
            mode_nxt = MODE_IDLE;
            hcnt_nxt = 2'd0;
            cp_nxt   = 12'd0;
            grp.cnt  = 2'd1;
            grp.kind = KIND_ERROR;
            grp.err  = ERR_HEX;
          end else if (hcnt_r == 2'd3) begin
            mode_nxt = MODE_STRING;
            hcnt_nxt = 2'd0;
            cp_nxt   = 12'd0;
            grp.kind = KIND_DATA;
            if (cp_full[15:7] == 9'd0) begin
              grp.cnt = 2'd1;
              grp.b0  = cp_full[7:0];
            end else if (cp_full[15:11] == 5'd0) begin
              grp.cnt = 2'd2;
              grp.b0  = {3'b110, cp_full[10:6]};
              grp.b1  = {2'b10, cp_full[5:0]};
            end else begin
              grp.cnt = 2'd3;
              grp.b0  = {4'b1110, cp_full[15:12]};
              grp.b1  = {2'b10, cp_full[11:6]};
              grp.b2  = {2'b10, cp_full[5:0]};
            end
          end else begin
            hcnt_nxt = hcnt_r + 2'd1;
            cp_nxt   = cp_full[11:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      hcnt_r <= 2'd0;
      cp_r   <= 12'd0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      hcnt_r <= hcnt_nxt;
      cp_r   <= cp_nxt;
    end
  end

endmodule

// ===== rtl/jsu_out.sv =====
// result group register and serializer onto the output stream
module jsu_out
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  jsu_grp_t   grp_in,
  output logic       grp_free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic [3:0] out_tuser,  // kind, error_code
  output logic       out_tlast
);

  jsu_grp_t   grp_r;
  logic       grp_v_r;
  logic [1:0] idx_r;
  logic       idx_last;
  logic       take;

  assign idx_last   = (idx_r == (grp_r.cnt - 2'd1));
  assign take       = grp_v_r && out_tready;
  assign grp_free   = !grp_v_r || (out_tready && idx_last);
  assign out_tvalid = grp_v_r;
  assign out_tuser  = {grp_r.err, grp_r.kind};
  assign out_tlast  = idx_last;

  always_comb begin
    case (idx_r)
      2'd0:    out_tdata = grp_r.b0;
      2'd1:    out_tdata = grp_r.b1;
      default: out_tdata = grp_r.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      grp_v_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (take) begin
      if (idx_last) begin
        grp_v_r <= 1'b0;
        idx_r   <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

endmodule

// ===== rtl/json_string_unescape_unit.sv =====
// json string unescape unit: byte stream in, decoded string bytes and status out
// path: input register, combinational decode, then the result register to the output
// throughput: one text byte per cycle while the result register is free; it sends one
// result per cycle while out_tready is high, so a \u unit's bytes stall the next request
// reset: synchronous rst_n clears the input and result valids and the parser to idle
module json_string_unescape_unit
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // input_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic [3:0] out_tuser,  // kind, error_code
  output logic       out_tlast   // last
);

  logic       in_v_r;
  logic [7:0] byte_r;
  logic       end_r;
  logic       advance;
  logic       grp_free;
  jsu_grp_t   dec_grp;

  assign advance   = in_v_r && ((dec_grp.cnt == 2'd0) || grp_free);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      end_r  <= in_tlast;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .in_byte (byte_r),
    .in_end  (end_r),
    .grp     (dec_grp)
  );

  jsu_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && (dec_grp.cnt != 2'd0)),
    .grp_in     (dec_grp),
    .grp_free   (grp_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sim/jsu_stream_checker.sv =====
// stream checker for the json string unescape unit: predicts each request's results and compares
module jsu_stream_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // input_end
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // out_byte
  input  logic [3:0] out_tuser,  // kind, error_code
  input  logic       out_tlast,  // last
  output int         fail_count,
  output int         pending_count
);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [1:0] err;
    logic       last;
  } decoded_t;

  decoded_t   decoded_q[$];
  decoded_t   step_res[3];
  int         step_n;
  int         miss_n = 0;
  decoded_t   got;
  decoded_t   want;

  logic [1:0]  mode;
  logic [1:0]  hex_cnt;
  logic [15:0] code_pt;

  task automatic go_idle();
    mode    = MODE_IDLE;
    hex_cnt = 2'd0;
    code_pt = 16'h0000;
  endtask

  task automatic add_result(input logic [7:0] data, input logic [1:0] kind,
                            input logic [1:0] err);
    step_res[step_n] = '{data: data, kind: kind, err: err, last: 1'b0};
    step_n++;
  endtask

  task automatic unescape_step(input logic [7:0] c, input logic fin);
    logic [3:0]  nib;
    logic        nib_ok;
    logic [15:0] cp;
    decoded_t    r;
    step_n = 0;
    if (fin) begin
      if (mode != MODE_IDLE) begin
        go_idle();
        add_result(8'h00, KIND_ERROR, ERR_END);
      end
    end else begin
      case (mode)
        MODE_IDLE: begin
          if (c == "\"") begin
            mode = MODE_STRING;
          end else if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0d))) begin
            add_result(8'h00, KIND_ERROR, ERR_NOTSTR);
          end
        end
        MODE_STRING: begin
          if (c == "\"") begin
            go_idle();
            add_result(8'h00, KIND_DONE, 2'd0);
          end else if (c == "\\") begin
            mode = MODE_ESCAPE;
          end else begin
            add_result(c, KIND_DATA, 2'd0);
          end
        end
        MODE_ESCAPE: begin
          mode = MODE_STRING;
          case (c)
            "\"", "/", "\\": add_result(c, KIND_DATA, 2'd0);
            "b": add_result(8'h08, KIND_DATA, 2'd0);
            "f": add_result(8'h0c, KIND_DATA, 2'd0);
            "n": add_result(8'h0a, KIND_DATA, 2'd0);
            "r": add_result(8'h0d, KIND_DATA, 2'd0);
            "t": add_result(8'h09, KIND_DATA, 2'd0);
            "u": begin
              mode    = MODE_HEX;
              hex_cnt = 2'd0;
              code_pt = 16'h0000;
            end
            default: begin
              go_idle();
              add_result(8'h00, KIND_ERROR, ERR_ESCAPE);
            end
          endcase
        end
        default: begin
          nib_ok = 1'b1;
          nib    = 4'd0;
          if (c >= "0" && c <= "9") nib = 4'(c - "0");
          else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
          else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
          else nib_ok = 1'b0;
          if (!nib_ok) begin
            go_idle();
            add_result(8'h00, KIND_ERROR, ERR_HEX);
          end else begin
            cp = {code_pt[11:0], nib};
            if (hex_cnt == 2'd3) begin
              mode    = MODE_STRING;
              hex_cnt = 2'd0;
              code_pt = 16'h0000;
              // utf-8 form of one code unit, no surrogate pairing
              if (cp <= 16'h007f) begin
                add_result(cp[7:0], KIND_DATA, 2'd0);
              end else if (cp <= 16'h07ff) begin
                add_result({3'b110, cp[10:6]}, KIND_DATA, 2'd0);
                add_result({2'b10, cp[5:0]}, KIND_DATA, 2'd0);
              end else begin
                add_result({4'b1110, cp[15:12]}, KIND_DATA, 2'd0);
                add_result({2'b10, cp[11:6]}, KIND_DATA, 2'd0);
                add_result({2'b10, cp[5:0]}, KIND_DATA, 2'd0);
              end
            end else begin
              code_pt = cp;
              hex_cnt = hex_cnt + 2'd1;
            end
          end
        end
      endcase
    end
    for (int i = 0; i < step_n; i++) begin
      r      = step_res[i];
      r.last = (i == step_n - 1);
      decoded_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      go_idle();
      decoded_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata, kind: out_tuser[1:0], err: out_tuser[3:2], last: out_tlast};
        if (decoded_q.size() == 0) begin
          if (miss_n < 10)
            $display("unexpected result: data %h kind %0d err %0d last %0d",
                     got.data, got.kind, got.err, got.last);
          miss_n++;
        end else begin
          want = decoded_q.pop_front();
          if (got.data !== want.data || got.kind !== want.kind ||
              got.err !== want.err || got.last !== want.last) begin
            if (miss_n < 10) begin
              $write("mismatch: expected data %h kind %0d err %0d last %0d,",
                     want.data, want.kind, want.err, want.last);
              $display(" got data %h kind %0d err %0d last %0d",
                       got.data, got.kind, got.err, got.last);
            end
            miss_n++;
          end
        end
      end
      if (in_tvalid && in_tready) unescape_step(in_tdata, in_tlast);
    end
    fail_count    <= miss_n;
    pending_count <= decoded_q.size();
  end

endmodule

// ===== sim/tb_json_string_unescape_unit.sv =====
// testbench top for the json string unescape unit: json text stimulus, stalls and verdict
module tb_json_string_unescape_unit;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // in_byte
  logic       in_tlast;   // input_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;  // out_byte
  logic [3:0] out_tuser;  // kind, error_code
  logic       out_tlast;  // last
  int         fail_count;
  int         pending_count;

  text_item_t text_q[$];
  int         drain_at;
  int         cycle_n = 0;
  logic [5:0] stall_phase = 6'd0;
  logic [1:0] stall_style = 2'd0;
  logic [7:0] esc_letters [8] = '{"\"", "/", "\\", "b", "f", "n", "r", "t"};

  always #1 clk = ~clk;

  json_string_unescape_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  jsu_stream_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  task automatic add_byte(input logic [7:0] b);
    text_q.push_back('{data: b, fin: 1'b0});
  endtask

  task automatic add_end();
    text_q.push_back('{data: 8'($urandom), fin: 1'b1});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(0, 1) ? "A" : "a") + v - 8'd10;
  endfunction

  // bad_at 0..3 puts a non-hex byte at that digit, 4 keeps the unit well formed
  task automatic add_u_unit(input logic [15:0] cp, input int bad_at);
    logic [7:0] b;
    add_byte("\\");
    add_byte("u");
    for (int i = 0; i < 4; i++) begin
      if (i == bad_at) begin
        do b = 8'($urandom);
        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
        add_byte(b);
        return;
      end
      add_byte(hex_char(cp[15 - 4 * i -: 4]));
    end
  endtask

  task automatic add_content();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        do b = 8'($urandom);
        while (b == "\"" || b == "\\");
        add_byte(b);
      end
      3: begin
        add_byte("\\");
        add_byte(esc_letters[$urandom_range(0, 7)]);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: add_u_unit(16'($urandom_range(0, 16'h007f)), 4);
          1: add_u_unit(16'($urandom_range(16'h0080, 16'h07ff)), 4);
          default: add_u_unit(16'($urandom_range(16'h0800, 16'hffff)), 4);
        endcase
      end
    endcase
  endtask

  task automatic add_random_part();
    logic [7:0] b;
    logic       bad;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      repeat ($urandom_range(0, 2))
        add_byte($urandom_range(0, 5) == 5 ? 8'h20 : 8'($urandom_range(8'h09, 8'h0d)));
      add_byte("\"");
      repeat ($urandom_range(0, 8)) add_content();
      add_byte("\"");
    end else if (pick < 88) begin
      add_byte("\"");
      repeat ($urandom_range(0, 3)) add_content();
      case ($urandom_range(0, 3))
        0: begin
          add_byte("\\");
          do begin
            b   = 8'($urandom);
            bad = (b == "u");
            foreach (esc_letters[k]) if (b == esc_letters[k]) bad = 1'b1;
          end while (bad);
          add_byte(b);
        end
        1: add_u_unit(16'($urandom), $urandom_range(0, 3));
        2: add_end();
        default: begin
          add_byte("\\");
          if ($urandom_range(0, 1)) begin
            add_byte("u");
            repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom)));
          end
          add_end();
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
      add_end();
    end
  endtask

  // receiver: switches between stall styles each time the 6-bit stall_phase counter wraps
  always @(posedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == 6'd0) stall_style <= 2'($urandom_range(0, 3));
    case (stall_style)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= (stall_phase[2:0] == 3'd7);
    endcase
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int gap;
    int burst;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;

    add_byte(8'h0b);
    add_end();
    add_text("x");
    add_text("\"");
    add_byte(8'h00);
    add_byte(8'hff);
    add_text("\\\"\\u0000\\uFfFF\"");
    add_text("\"\\q");
    add_text("\"\\u1G");
    add_text("\"a");
    add_end();
    drain_at = text_q.size();
    while (text_q.size() < drain_at + 150) add_random_part();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    burst = 0;
    for (int k = 0; k < text_q.size(); k++) begin
      if (k == drain_at) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
      end
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= text_q[k].data;
      in_tlast  <= text_q[k].fin;
      do @(posedge clk);
      while (!in_tready);
      burst--;
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
